// File: src/pssh_pkg.sv
// pssh_pkg: types, constants and palette tables for the planar sprite converter.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package pssh_pkg;

  // Field and port widths fixed by the item format
  localparam int PLANE_W       = 8;
  localparam int PIX_PER_GROUP = 8;
  localparam int BIT_IDX_W     = 3;
  localparam int ADDR_FIELD_W  = 20;
  localparam int COLOR_W       = 32;
  localparam int IDX_W         = 4;
  localparam int ROW_W         = 14;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 7;
  localparam int FILLER_W      = 4;
  localparam int MODE_W        = 2;

  // Plane queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Parameter defaults
  localparam int DEF_MAX_SPRITE_DIM    = 64;
  localparam int DEF_MAX_STRIDE        = 64;
  localparam int DEF_ADDRESS_BITS      = 20;
  localparam int DEF_SPRITES_PER_CHUNK = 50;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] RST_SPRITE_WIDTH  = 7'd16;
  localparam logic [CFG_DATA_W-1:0] RST_SPRITE_HEIGHT = 7'd16;
  localparam logic [CFG_DATA_W-1:0] RST_SHEET_STRIDE  = 7'd50;
  localparam logic [FILLER_W-1:0]   RST_FILLER_SLOTS  = 4'd2;
  localparam logic [MODE_W-1:0]     RST_PALETTE_MODE  = 2'd0;

  localparam logic [CFG_DATA_W-1:0] WIDTH_KEEP_MASK = 7'h78;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPRITE_WIDTH  = 3'd0,
    CFG_SPRITE_HEIGHT = 3'd1,
    CFG_SHEET_STRIDE  = 3'd2,
    CFG_FILLER_SLOTS  = 3'd3,
    CFG_PALETTE_MODE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    PAL_NORMAL = 2'd0,
    PAL_DARK   = 2'd1,
    PAL_NIGHT  = 2'd2
  } pal_mode_t;

  typedef enum logic {
    BK_RUN  = 1'b0,
    BK_SKIP = 1'b1
  } bk_state_t;

  typedef struct packed {
    logic [PLANE_W-1:0] transparency_plane;
    logic [PLANE_W-1:0] blue_plane;
    logic [PLANE_W-1:0] green_plane;
    logic [PLANE_W-1:0] red_plane;
    logic [PLANE_W-1:0] intensity_plane;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_FIELD_W-1:0] pixel_address;
    logic [COLOR_W-1:0]      pixel_color;
    logic                    address_overflow;
    logic                    last_pixel;
  } out_item_t;

  // One pixel after classification: opacity and IRGB palette index
  typedef struct packed {
    logic             opaque;
    logic [IDX_W-1:0] idx;
  } pix_code_t;

  // Entry n holds the pixel of plane bit n (bit 7 is leftmost)
  typedef pix_code_t [PIX_PER_GROUP-1:0] group_t;

  localparam logic [COLOR_W-1:0] PAL_NORMAL_TAB [16] = '{
    32'hFF000000, 32'hFF0000AA, 32'hFF00AA00, 32'hFF00AAAA,
    32'hFFAA0000, 32'hFFAA00AA, 32'hFFAA5500, 32'hFFAAAAAA,
    32'hFF555555, 32'hFF5555FF, 32'hFF55FF55, 32'hFF55FFFF,
    32'hFFFF5555, 32'hFFFF55FF, 32'hFFFFFF55, 32'hFFFFFFFF
  };
  localparam logic [COLOR_W-1:0] PAL_DARK_TAB [16] = '{
    32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000,
    32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000,
    32'hFF000000, 32'hFF0000AA, 32'hFF00AA00, 32'hFF00AAAA,
    32'hFFAA0000, 32'hFFAA00AA, 32'hFFAA5500, 32'hFFAAAAAA
  };
  localparam logic [COLOR_W-1:0] PAL_NIGHT_TAB [16] = '{
    32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000,
    32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF12073E,
    32'hFF050526, 32'hFF12073E, 32'hFF201254, 32'hFF241B67,
    32'hFF241B67, 32'hFF242472, 32'hFF242472, 32'hFF4576A3
  };

  // Look up the ARGB word; the unused mode code falls back to the normal table
  function automatic logic [COLOR_W-1:0] palette_lookup(logic [MODE_W-1:0] mode,
                                                        logic [IDX_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    unique case (mode)
      PAL_DARK:  c = PAL_DARK_TAB[idx];
      PAL_NIGHT: c = PAL_NIGHT_TAB[idx];
      default:   c = PAL_NORMAL_TAB[idx];
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: src/pssh_front.sv
// pssh_front: accepts plane groups, splits them into per-pixel codes and queues them.
// Depends on pssh_pkg.
`default_nettype none
module pssh_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pssh_pkg::in_item_t in_data,
  output logic                   head_valid,
  output pssh_pkg::group_t       head_group,
  input  wire logic              pop
);

  pssh_pkg::group_t                 grp_in;
  pssh_pkg::group_t                 q_mem_r [pssh_pkg::QUEUE_DEPTH];
  logic [pssh_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [pssh_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [pssh_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                             push;

  // Classify each pixel: opacity bit and IRGB index
  always_comb begin
    for (int i = 0; i < pssh_pkg::PIX_PER_GROUP; i++) begin
      grp_in[i].opaque = in_data.transparency_plane[i];
      grp_in[i].idx    = {in_data.intensity_plane[i], in_data.red_plane[i],
                          in_data.green_plane[i], in_data.blue_plane[i]};
    end
  end

  assign in_stall   = (count_r == pssh_pkg::QCNT_W'(pssh_pkg::QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count_r != '0);
  assign head_group = q_mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == pssh_pkg::QPTR_W'(pssh_pkg::QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == pssh_pkg::QPTR_W'(pssh_pkg::QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the classified group
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= grp_in;
    end
  end

endmodule
`default_nettype wire

// File: src/pssh_back.sv
// pssh_back: walks sprite and slot counters, one pixel a cycle unless stalled or starved,
// and forms address and colour in a four-stage pipeline ending in the output register.
// Depends on pssh_pkg.
`default_nettype none
module pssh_back #(
  parameter int MAX_SPRITE_DIM    = pssh_pkg::DEF_MAX_SPRITE_DIM,
  parameter int MAX_STRIDE        = pssh_pkg::DEF_MAX_STRIDE,
  parameter int ADDRESS_BITS      = pssh_pkg::DEF_ADDRESS_BITS,
  parameter int SPRITES_PER_CHUNK = pssh_pkg::DEF_SPRITES_PER_CHUNK,
  localparam int DIM_W   = $clog2(MAX_SPRITE_DIM + 1),
  localparam int STR_W   = $clog2(MAX_STRIDE + 1),
  localparam int PITCH_W = DIM_W + STR_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            head_valid,
  input  wire pssh_pkg::group_t                head_group,
  output logic                                 pop,
  input  wire logic [DIM_W-1:0]                width,
  input  wire logic [DIM_W-1:0]                height,
  input  wire logic [STR_W-1:0]                stride,
  input  wire logic [PITCH_W-1:0]              pitch,
  input  wire logic [pssh_pkg::FILLER_W-1:0]   filler,
  input  wire logic [pssh_pkg::MODE_W-1:0]     mode,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output pssh_pkg::out_item_t                  out_data
);

  localparam int PX_W   = $clog2(MAX_SPRITE_DIM);
  localparam int COL_W  = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
  localparam int CNK_W  = (SPRITES_PER_CHUNK > 1) ? $clog2(SPRITES_PER_CHUNK) : 1;
  localparam int ROW_W  = pssh_pkg::ROW_W;
  localparam int X_W    = COL_W + DIM_W + 1;
  localparam int Y_W    = ROW_W + DIM_W + 1;
  localparam int PROD_W = Y_W + PITCH_W;
  localparam int S0_W   = ((PROD_W > X_W) ? PROD_W : X_W) + 1;
  localparam int S1_W   = (S0_W > ADDRESS_BITS + 1) ? S0_W : ADDRESS_BITS + 1;
  localparam int SUM_W  = (S1_W > pssh_pkg::ADDR_FIELD_W) ? S1_W : pssh_pkg::ADDR_FIELD_W;
  localparam logic [SUM_W-1:0] AMASK = {{(SUM_W - ADDRESS_BITS){1'b0}},
                                        {ADDRESS_BITS{1'b1}}};

  // Sequencer state
  pssh_pkg::bk_state_t                 state_r, state_nxt;
  logic [pssh_pkg::BIT_IDX_W-1:0]      bit_r, bit_nxt;
  logic [PX_W-1:0]                     px_r, px_nxt, py_r, py_nxt;
  logic [COL_W-1:0]                    col_r, col_nxt;
  logic [ROW_W-1:0]                    row_r, row_nxt;
  logic [CNK_W-1:0]                    cnk_r, cnk_nxt;
  logic [pssh_pkg::FILLER_W-1:0]       skip_r, skip_nxt;

  logic                                en, issue;
  logic [COL_W:0]                      col_inc;
  logic                                col_wrap;
  logic [COL_W-1:0]                    slot_col;
  logic [ROW_W-1:0]                    slot_row;
  logic [PX_W:0]                       px_inc, py_inc;
  logic [CNK_W:0]                      cnk_inc;
  pssh_pkg::pix_code_t                 pix;

  // Pipeline stages
  logic                                v1_r, v2_r, v3_r;
  logic [COL_W-1:0]                    col_s1_r;
  logic [ROW_W-1:0]                    row_s1_r;
  logic [PX_W-1:0]                     px_s1_r, py_s1_r;
  logic [pssh_pkg::COLOR_W-1:0]        color_s1_r, color_s2_r, color_s3_r;
  logic                                last_s1_r, last_s2_r, last_s3_r;
  logic [X_W-1:0]                      x_s2_r, x_s3_r;
  logic [Y_W-1:0]                      y_s2_r;
  logic [PROD_W-1:0]                   prod_s3_r;
  logic [SUM_W-1:0]                    sum;
  logic                                out_valid_r;
  pssh_pkg::out_item_t                 out_data_r;

  assign en    = !(out_valid_r && out_stall);
  assign issue = (state_r == pssh_pkg::BK_RUN) && head_valid && en;
  assign pop   = issue && (bit_r == pssh_pkg::BIT_IDX_W'(pssh_pkg::PIX_PER_GROUP - 1));
  assign pix   = head_group[~bit_r];

  // One slot step: next column, wrapping to the next sheet row
  always_comb begin
    col_inc  = {1'b0, col_r} + 1'b1;
    col_wrap = (32'(col_inc) >= 32'(stride));
    slot_col = col_wrap ? '0 : COL_W'(col_inc);
    slot_row = col_wrap ? row_r + 1'b1 : row_r;
  end

  // Next state: advance pixel counters on issue, skip filler slots one a cycle
  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    cnk_nxt   = cnk_r;
    skip_nxt  = skip_r;
    px_inc    = {1'b0, px_r} + 1'b1;
    py_inc    = {1'b0, py_r} + 1'b1;
    cnk_inc   = {1'b0, cnk_r} + 1'b1;
    unique case (state_r)
      pssh_pkg::BK_SKIP: begin
        col_nxt  = slot_col;
        row_nxt  = slot_row;
        skip_nxt = skip_r - 1'b1;
        if (skip_r == pssh_pkg::FILLER_W'(1)) begin
          state_nxt = pssh_pkg::BK_RUN;
        end
      end
      default: begin
        if (issue) begin
          bit_nxt = bit_r + 1'b1;
          if (32'(px_inc) < 32'(width)) begin
            px_nxt = PX_W'(px_inc);
          end else begin
            px_nxt = '0;
            if (32'(py_inc) < 32'(height)) begin
              py_nxt = PX_W'(py_inc);
            end else begin
              py_nxt  = '0;
              col_nxt = slot_col;
              row_nxt = slot_row;
              if (32'(cnk_inc) >= SPRITES_PER_CHUNK) begin
                cnk_nxt = '0;
                if (filler != '0) begin
                  state_nxt = pssh_pkg::BK_SKIP;
                  skip_nxt  = filler;
                end
              end else begin
                cnk_nxt = CNK_W'(cnk_inc);
              end
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pssh_pkg::BK_RUN;
      bit_r   <= '0;
      px_r    <= '0;
      py_r    <= '0;
      col_r   <= '0;
      row_r   <= '0;
      cnk_r   <= '0;
      skip_r  <= '0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      cnk_r   <= cnk_nxt;
      skip_r  <= skip_nxt;
    end
  end

  // Pipeline valids; the whole pipe holds while the output is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= issue;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  assign sum = SUM_W'(prod_s3_r) + SUM_W'(x_s3_r);

  // Stage payloads: colour lookup, x/y products, row offset, final add
  always_ff @(posedge clk) begin
    if (en) begin
      col_s1_r   <= col_r;
      row_s1_r   <= row_r;
      px_s1_r    <= px_r;
      py_s1_r    <= py_r;
      color_s1_r <= pix.opaque ? pssh_pkg::palette_lookup(mode, pix.idx) : '0;
      last_s1_r  <= (bit_r == pssh_pkg::BIT_IDX_W'(pssh_pkg::PIX_PER_GROUP - 1));

      x_s2_r     <= X_W'(col_s1_r) * X_W'(width) + X_W'(px_s1_r);
      y_s2_r     <= Y_W'(row_s1_r) * Y_W'(height) + Y_W'(py_s1_r);
      color_s2_r <= color_s1_r;
      last_s2_r  <= last_s1_r;

      prod_s3_r  <= PROD_W'(y_s2_r) * PROD_W'(pitch);
      x_s3_r     <= x_s2_r;
      color_s3_r <= color_s2_r;
      last_s3_r  <= last_s2_r;

      out_data_r.pixel_address    <= pssh_pkg::ADDR_FIELD_W'(sum & AMASK);
      out_data_r.pixel_color      <= color_s3_r;
      out_data_r.address_overflow <= |(sum >> ADDRESS_BITS);
      out_data_r.last_pixel       <= last_s3_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: src/planar_sprite_to_argb_sheet.sv
// planar_sprite_to_argb_sheet: top level; configuration registers, geometry
// clamping, and the front (classify and queue) and back (pixel sequencer) parts.
// Depends on pssh_pkg, pssh_front and pssh_back.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall    pssh_pkg::in_item_t (five plane bytes)
//   out_     output     out_valid / out_stall  pssh_pkg::out_item_t (one pixel)
//   cfg_     input      cfg_wen (no wait)      cfg_index, cfg_wdata
//
// Each plane group gives eight pixels at one a cycle while the output is not stalled,
// a pace set by the back sequencer; after a completed chunk of SPRITES_PER_CHUNK sprites,
// pixel issue pauses while the slot counters step through the filler_slots empty slots.
// An issued pixel passes through stages s1, s2 and s3 and then the output register.
// Reset (rst_n low, synchronous) empties the queue and pipe, zeroes all counters
// and loads the register defaults. A stalled output freezes pixel issue and the
// whole pipe; the two-entry queue keeps taking groups until it is full.
`default_nettype none
module planar_sprite_to_argb_sheet #(
  parameter int MAX_SPRITE_DIM    = pssh_pkg::DEF_MAX_SPRITE_DIM,
  parameter int MAX_STRIDE        = pssh_pkg::DEF_MAX_STRIDE,
  parameter int ADDRESS_BITS      = pssh_pkg::DEF_ADDRESS_BITS,
  parameter int SPRITES_PER_CHUNK = pssh_pkg::DEF_SPRITES_PER_CHUNK
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire pssh_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output pssh_pkg::out_item_t                    out_data,
  input  wire logic                              cfg_wen,
  input  wire logic [pssh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pssh_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DIM_W   = $clog2(MAX_SPRITE_DIM + 1);
  localparam int STR_W   = $clog2(MAX_STRIDE + 1);
  localparam int PITCH_W = DIM_W + STR_W;
  localparam int MAXW    = (MAX_SPRITE_DIM / 8) * 8;

  logic [pssh_pkg::CFG_DATA_W-1:0] width_cfg_r, height_cfg_r, stride_cfg_r;
  logic [pssh_pkg::FILLER_W-1:0]   filler_cfg_r;
  logic [pssh_pkg::MODE_W-1:0]     mode_cfg_r;

  int                              w_int, h_int, s_int;
  logic [DIM_W-1:0]                w_eff, h_eff;
  logic [STR_W-1:0]                s_eff;
  logic [PITCH_W-1:0]              pitch_nxt;
  logic [DIM_W-1:0]                width_r, height_r;
  logic [STR_W-1:0]                stride_r;
  logic [PITCH_W-1:0]              pitch_r;

  logic                            head_valid, pop;
  pssh_pkg::group_t                head_group;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= pssh_pkg::RST_SPRITE_WIDTH;
      height_cfg_r <= pssh_pkg::RST_SPRITE_HEIGHT;
      stride_cfg_r <= pssh_pkg::RST_SHEET_STRIDE;
      filler_cfg_r <= pssh_pkg::RST_FILLER_SLOTS;
      mode_cfg_r   <= pssh_pkg::RST_PALETTE_MODE;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        pssh_pkg::CFG_SPRITE_WIDTH:  width_cfg_r  <= cfg_wdata;
        pssh_pkg::CFG_SPRITE_HEIGHT: height_cfg_r <= cfg_wdata;
        pssh_pkg::CFG_SHEET_STRIDE:  stride_cfg_r <= cfg_wdata;
        pssh_pkg::CFG_FILLER_SLOTS:  filler_cfg_r <= pssh_pkg::FILLER_W'(cfg_wdata);
        pssh_pkg::CFG_PALETTE_MODE:  mode_cfg_r   <= pssh_pkg::MODE_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Clamp geometry: width to a multiple of eight, zero to the minimum, cap at maxima
  always_comb begin
    w_int = int'(width_cfg_r & pssh_pkg::WIDTH_KEEP_MASK);
    if (w_int == 0)   w_int = 8;
    if (w_int > MAXW) w_int = MAXW;
    h_int = int'(height_cfg_r);
    if (h_int == 0)              h_int = 1;
    if (h_int > MAX_SPRITE_DIM)  h_int = MAX_SPRITE_DIM;
    s_int = int'(stride_cfg_r);
    if (s_int == 0)          s_int = 1;
    if (s_int > MAX_STRIDE)  s_int = MAX_STRIDE;
    w_eff     = DIM_W'(w_int);
    h_eff     = DIM_W'(h_int);
    s_eff     = STR_W'(s_int);
    pitch_nxt = {{STR_W{1'b0}}, w_eff} * {{DIM_W{1'b0}}, s_eff};
  end

  // Hold clamped geometry and row pitch in registers
  always_ff @(posedge clk) begin
    width_r  <= w_eff;
    height_r <= h_eff;
    stride_r <= s_eff;
    pitch_r  <= pitch_nxt;
  end

  pssh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head_group (head_group),
    .pop        (pop)
  );

  pssh_back #(
    .MAX_SPRITE_DIM    (MAX_SPRITE_DIM),
    .MAX_STRIDE        (MAX_STRIDE),
    .ADDRESS_BITS      (ADDRESS_BITS),
    .SPRITES_PER_CHUNK (SPRITES_PER_CHUNK)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_group (head_group),
    .pop        (pop),
    .width      (width_r),
    .height     (height_r),
    .stride     (stride_r),
    .pitch      (pitch_r),
    .filler     (filler_cfg_r),
    .mode       (mode_cfg_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// File: src/pssh_checker.sv
// pssh_checker: port-level checks on the converter, bound to its top level.
// Depends on pssh_pkg and planar_sprite_to_argb_sheet.
`default_nettype none
module pssh_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire pssh_pkg::out_item_t out_data
);

  // A stalled pixel stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output pixel changed or dropped");

  // Leaving reset: nothing to show and room to take a group
  a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid && !in_stall)
    else $error("output valid or input stalled straight after reset");

  // Every opaque colour carries a full alpha byte
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pixel_color != '0) |-> out_data.pixel_color[31:24] == 8'hFF)
    else $error("opaque pixel without full alpha");

  // The closing pixel of a group is never followed at once by another closing pixel
  a_last_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_pixel |=> !(out_valid && out_data.last_pixel))
    else $error("two group-closing pixels back to back");

  // An idle input straight after reset is never stalled
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) && !in_valid |-> !in_stall)
    else $error("input stalled while idle after reset");

endmodule

bind planar_sprite_to_argb_sheet pssh_checker u_pssh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// File: verif/tb_planar_sprite_to_argb_sheet.sv
// Self-checking testbench for planar_sprite_to_argb_sheet: plane groups in, ARGB pixels out.
// Keeps its own model of the sheet counters and palettes; depends on pssh_pkg and the RTL.
`timescale 1ns / 100ps
module tb_planar_sprite_to_argb_sheet;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED    = 40;
  localparam int MAX_DIM        = pssh_pkg::DEF_MAX_SPRITE_DIM;
  localparam int MAX_STRIDE_V   = pssh_pkg::DEF_MAX_STRIDE;
  localparam int CHUNK_SPRITES  = pssh_pkg::DEF_SPRITES_PER_CHUNK;
  localparam int PIXELS         = pssh_pkg::PIX_PER_GROUP;
  localparam int DW             = pssh_pkg::CFG_DATA_W;
  localparam int FW             = pssh_pkg::FILLER_W;
  localparam int MW             = pssh_pkg::MODE_W;
  localparam int IW             = pssh_pkg::IDX_W;
  localparam int CW             = pssh_pkg::COLOR_W;
  localparam logic [63:0] ADDR_MASK = (64'd1 << pssh_pkg::DEF_ADDRESS_BITS) - 64'd1;
  localparam int unsigned ROW_MASK  = (1 << pssh_pkg::ROW_W) - 1;

  localparam logic [CW-1:0] ARGB_NORMAL [16] = '{
    32'hFF000000, 32'hFF0000AA, 32'hFF00AA00, 32'hFF00AAAA,
    32'hFFAA0000, 32'hFFAA00AA, 32'hFFAA5500, 32'hFFAAAAAA,
    32'hFF555555, 32'hFF5555FF, 32'hFF55FF55, 32'hFF55FFFF,
    32'hFFFF5555, 32'hFFFF55FF, 32'hFFFFFF55, 32'hFFFFFFFF
  };
  localparam logic [CW-1:0] ARGB_DARK [16] = '{
    32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000,
    32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000,
    32'hFF000000, 32'hFF0000AA, 32'hFF00AA00, 32'hFF00AAAA,
    32'hFFAA0000, 32'hFFAA00AA, 32'hFFAA5500, 32'hFFAAAAAA
  };
  localparam logic [CW-1:0] ARGB_NIGHT [16] = '{
    32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF000000,
    32'hFF000000, 32'hFF000000, 32'hFF000000, 32'hFF12073E,
    32'hFF050526, 32'hFF12073E, 32'hFF201254, 32'hFF241B67,
    32'hFF241B67, 32'hFF242472, 32'hFF242472, 32'hFF4576A3
  };

  // DUT ports
  logic                                clk       = 1'b0;
  logic                                rst_n     = 1'b0;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  pssh_pkg::in_item_t                  in_data   = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  pssh_pkg::out_item_t                 out_data;
  logic                                cfg_wen   = 1'b0;
  logic [pssh_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [DW-1:0]                       cfg_wdata = '0;

  // Register copies, loaded with the reset values
  logic [DW-1:0] width_reg  = pssh_pkg::RST_SPRITE_WIDTH;
  logic [DW-1:0] height_reg = pssh_pkg::RST_SPRITE_HEIGHT;
  logic [DW-1:0] stride_reg = pssh_pkg::RST_SHEET_STRIDE;
  logic [FW-1:0] filler_reg = pssh_pkg::RST_FILLER_SLOTS;
  logic [MW-1:0] mode_reg   = pssh_pkg::RST_PALETTE_MODE;

  // Sheet position, wide enough that a stale counter behaves as in unbounded arithmetic
  int unsigned sheet_col   = 0;
  int unsigned sheet_row   = 0;
  int unsigned spr_x       = 0;
  int unsigned spr_y       = 0;
  int unsigned chunk_count = 0;

  pssh_pkg::out_item_t pixel_queue [$];

  // Run statistics
  int unsigned mismatches     = 0;
  int unsigned groups_sent    = 0;
  int unsigned pixels_checked = 0;
  int unsigned settings_count = 0;
  int unsigned overflow_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned stall_left     = 0;
  bit          quiet_in       = 1'b0;
  bit          quiet_out      = 1'b0;

  planar_sprite_to_argb_sheet DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sheet model
  // ---------------------------------------------------------------------------

  function automatic logic [CW-1:0] argb_for(logic [MW-1:0] mode, logic [IW-1:0] idx);
    case (mode)
      pssh_pkg::PAL_DARK:  return ARGB_DARK[idx];
      pssh_pkg::PAL_NIGHT: return ARGB_NIGHT[idx];
      default:             return ARGB_NORMAL[idx];
    endcase
  endfunction

  // Move to the next slot on the sheet; the row wraps within its counter width
  task automatic step_slot(input int unsigned stride);
    sheet_col++;
    if (sheet_col >= stride) begin
      sheet_col = 0;
      sheet_row = (sheet_row + 1) & ROW_MASK;
    end
  endtask

  // Advance one pixel; a finished sprite moves the slot, a finished chunk skips fillers
  task automatic step_pixel(input int unsigned w, input int unsigned h,
                            input int unsigned stride);
    int unsigned k;
    spr_x++;
    if (spr_x < w) return;
    spr_x = 0;
    spr_y++;
    if (spr_y < h) return;
    spr_y = 0;
    step_slot(stride);
    chunk_count++;
    if (chunk_count >= CHUNK_SPRITES) begin
      chunk_count = 0;
      for (k = 0; k < filler_reg; k++) step_slot(stride);
    end
  endtask

  // Queue the eight pixels of one accepted group, leftmost first
  task automatic render_group(input pssh_pkg::in_item_t grp);
    int unsigned w, h, stride, bitpos, k;
    logic [63:0] x, y, pitch, addr;
    logic [IW-1:0] idx;
    pssh_pkg::out_item_t pix;
    w = 32'(width_reg & pssh_pkg::WIDTH_KEEP_MASK);
    if (w == 0) w = 8;
    if (w > (MAX_DIM & ~7)) w = MAX_DIM & ~7;
    h = 32'(height_reg);
    if (h == 0) h = 1;
    if (h > MAX_DIM) h = MAX_DIM;
    stride = 32'(stride_reg);
    if (stride == 0) stride = 1;
    if (stride > MAX_STRIDE_V) stride = MAX_STRIDE_V;
    for (k = 0; k < PIXELS; k++) begin
      bitpos = 7 - k;
      x = 64'(sheet_col) * 64'(w) + 64'(spr_x);
      y = 64'(sheet_row) * 64'(h) + 64'(spr_y);
      pitch = 64'(stride) * 64'(w);
      addr = x + y * pitch;
      idx = {grp.intensity_plane[bitpos], grp.red_plane[bitpos],
             grp.green_plane[bitpos], grp.blue_plane[bitpos]};
      pix.pixel_address    = addr[pssh_pkg::ADDR_FIELD_W-1:0];
      pix.pixel_color      = grp.transparency_plane[bitpos] ? argb_for(mode_reg, idx) : '0;
      pix.address_overflow = (addr > ADDR_MASK);
      pix.last_pixel       = (k == PIXELS - 1);
      if (pix.address_overflow) overflow_count++;
      pixel_queue.push_back(pix);
      step_pixel(w, h, stride);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one group after a random gap and hold it until the block takes it
  task automatic send_group(input pssh_pkg::in_item_t grp);
    int unsigned gap;
    gap = quiet_in ? 0 : $urandom_range(11, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= grp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    render_group(grp);
    groups_sent++;
  endtask

  // Drop valid, wait for every pending pixel, then let the filler walk settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input pssh_pkg::cfg_reg_t idx, input logic [DW-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // Write all five registers once the block is idle
  task automatic set_config(input logic [DW-1:0] w, input logic [DW-1:0] h,
                            input logic [DW-1:0] stride,
                            input logic [FW-1:0] filler, input logic [MW-1:0] mode);
    drain();
    write_reg(pssh_pkg::CFG_SPRITE_WIDTH, w);
    write_reg(pssh_pkg::CFG_SPRITE_HEIGHT, h);
    write_reg(pssh_pkg::CFG_SHEET_STRIDE, stride);
    write_reg(pssh_pkg::CFG_FILLER_SLOTS, DW'(filler));
    write_reg(pssh_pkg::CFG_PALETTE_MODE, DW'(mode));
    cfg_wen    <= 1'b0;
    width_reg  = w;
    height_reg = h;
    stride_reg = stride;
    filler_reg = filler;
    mode_reg   = mode;
    settings_count++;
  endtask

  function automatic pssh_pkg::in_item_t planes(logic [7:0] t, logic [7:0] b,
                                                logic [7:0] g, logic [7:0] r,
                                                logic [7:0] i);
    pssh_pkg::in_item_t grp;
    grp.transparency_plane = t;
    grp.blue_plane         = b;
    grp.green_plane        = g;
    grp.red_plane          = r;
    grp.intensity_plane    = i;
    return grp;
  endfunction

  // Eight opaque pixels carrying palette indices first .. first+7
  function automatic pssh_pkg::in_item_t ramp_group(int unsigned first);
    pssh_pkg::in_item_t grp;
    logic [IW-1:0] idx;
    int unsigned p;
    grp = '0;
    grp.transparency_plane = 8'hFF;
    for (p = 0; p < PIXELS; p++) begin
      idx = IW'(first + p);
      grp.blue_plane[7-p]      = idx[0];
      grp.green_plane[7-p]     = idx[1];
      grp.red_plane[7-p]       = idx[2];
      grp.intensity_plane[7-p] = idx[3];
    end
    return grp;
  endfunction

  function automatic pssh_pkg::in_item_t random_planes();
    pssh_pkg::in_item_t grp;
    grp = planes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    case ($urandom_range(7, 0))
      0: grp.transparency_plane = 8'hFF;
      1: grp.transparency_plane = 8'h00;
      default: ;
    endcase
    return grp;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, compare, watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    // keep the log short if the block goes badly wrong; every mismatch still counts
    if (mismatches < MAX_PRINTED)
      $display("[%0t] MISMATCH %s: got %h, expected %h (pixel %0d)",
               $time, what, got, want, pixels_checked);
    mismatches++;
  endtask

  task automatic check_pixel(input pssh_pkg::out_item_t got);
    pssh_pkg::out_item_t want;
    if (pixel_queue.size() == 0) begin
      report_mismatch("unexpected pixel, address", 32'(got.pixel_address), '0);
      return;
    end
    want = pixel_queue.pop_front();
    if (got.pixel_address !== want.pixel_address)
      report_mismatch("pixel_address", 32'(got.pixel_address), 32'(want.pixel_address));
    if (got.pixel_color !== want.pixel_color)
      report_mismatch("pixel_color", got.pixel_color, want.pixel_color);
    if (got.address_overflow !== want.address_overflow)
      report_mismatch("address_overflow", 32'(got.address_overflow),
                      32'(want.address_overflow));
    if (got.last_pixel !== want.last_pixel)
      report_mismatch("last_pixel", 32'(got.last_pixel), 32'(want.last_pixel));
    pixels_checked++;
  endtask

  // Take each pixel transaction, then hold stall for a freshly drawn count
  always @(posedge clk) begin : result_side
    int unsigned hold;
    if (rst_n) begin
      if (out_stall) begin
        if (stall_left <= 1) out_stall <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (out_valid) begin
        check_pixel(out_data);
        hold = quiet_out ? 0 : $urandom_range(11, 0);
        if (hold != 0) begin
          out_stall  <= 1'b1;
          stall_left <= hold;
        end
      end
    end
  end

  // End the run if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transaction for %0d cycles, %0d pixels pending",
               $time, idle_cycles, pixel_queue.size());
      $display("planar_sprite_to_argb_sheet test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register defaults after reset, with the plane extremes
  task automatic test_reset_defaults();
    send_group(planes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_group(planes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_group(planes(8'hA5, 8'hAA, 8'h55, 8'hCC, 8'h0F));
    // colour bits set but every pixel transparent
    send_group(planes(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
  endtask

  // All sixteen indices through each palette code, the unused code included
  task automatic test_palette_modes();
    logic [MW-1:0] mode;
    int unsigned m;
    for (m = 0; m < 4; m++) begin
      mode = MW'(m);
      set_config(7'd16, 7'd16, 7'd50, 4'd2, mode);
      send_group(ramp_group(0));
      send_group(ramp_group(8));
    end
  endtask

  // Zero and oversized geometry, and a width with its low bits set
  task automatic test_geometry_clamps();
    set_config(7'd0, 7'd0, 7'd0, 4'd0, pssh_pkg::PAL_NORMAL);
    send_group(random_planes());
    send_group(random_planes());
    set_config(7'd127, 7'd127, 7'd127, 4'd15, 2'd3);
    send_group(random_planes());
    send_group(random_planes());
    set_config(7'd13, 7'd5, 7'd65, 4'd1, pssh_pkg::PAL_NIGHT);
    send_group(random_planes());
    send_group(random_planes());
  endtask

  // Shrink the sprite while the counters sit beyond the new limits
  task automatic test_geometry_change();
    set_config(7'd64, 7'd64, 7'd3, 4'd2, pssh_pkg::PAL_NORMAL);
    repeat (3) send_group(random_planes());
    set_config(7'd8, 7'd2, 7'd3, 4'd2, pssh_pkg::PAL_DARK);
    repeat (2) send_group(random_planes());
    set_config(7'd8, 7'd64, 7'd3, 4'd2, pssh_pkg::PAL_NORMAL);
    repeat (3) send_group(random_planes());
    set_config(7'd8, 7'd2, 7'd3, 4'd2, pssh_pkg::PAL_NIGHT);
    repeat (2) send_group(random_planes());
  endtask

  // One-group sprites so whole chunks pass, with no fillers and with the most
  task automatic test_chunk_filler();
    set_config(7'd8, 7'd1, 7'd7, 4'd0, pssh_pkg::PAL_NORMAL);
    repeat (CHUNK_SPRITES + 3) send_group(random_planes());
    set_config(7'd8, 7'd1, 7'd7, 4'd15, pssh_pkg::PAL_DARK);
    repeat (CHUNK_SPRITES + 3) send_group(random_planes());
  endtask

  // Climb a few rows, then widen the pitch until addresses wrap
  task automatic test_address_overflow();
    quiet_in  = 1'b1;
    quiet_out = 1'b1;
    set_config(7'd8, 7'd1, 7'd1, 4'd15, pssh_pkg::PAL_NORMAL);
    repeat (12) send_group(random_planes());
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
    set_config(7'd64, 7'd64, 7'd64, 4'd3, pssh_pkg::PAL_NIGHT);
    repeat (12) send_group(random_planes());
    set_config(7'd64, 7'd64, 7'd1, 4'd3, pssh_pkg::PAL_NORMAL);
    repeat (4) send_group(random_planes());
  endtask

  // Single-slot rows with the most fillers, so the slot row climbs fast
  task automatic test_row_climb();
    quiet_in  = 1'b1;
    quiet_out = 1'b1;
    set_config(7'd8, 7'd1, 7'd1, 4'd15, pssh_pkg::PAL_DARK);
    repeat (12) send_group(random_planes());
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
    repeat (4) send_group(random_planes());
  endtask

  // Random settings per phase, mostly small sprites so slots and chunks turn over
  task automatic test_random_traffic();
    logic [DW-1:0] w, h, stride;
    int unsigned phase;
    for (phase = 0; phase < 8; phase++) begin
      case ($urandom_range(9, 0))
        0: begin
          w = DW'($urandom_range(127, 0));
          h = DW'($urandom_range(127, 0));
          stride = DW'($urandom_range(127, 0));
        end
        1: begin
          w = 7'd64;
          h = 7'd64;
          stride = 7'd64;
        end
        default: begin
          w = DW'(8 * $urandom_range(2, 1) + $urandom_range(7, 0));
          h = DW'($urandom_range(4, 1));
          stride = DW'($urandom_range(6, 1));
        end
      endcase
      quiet_in  = ($urandom_range(3, 0) == 0);
      quiet_out = ($urandom_range(3, 0) == 0);
      set_config(w, h, stride, FW'($urandom_range(15, 0)), MW'($urandom_range(3, 0)));
      repeat (16) send_group(random_planes());
    end
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_palette_modes();
    test_geometry_clamps();
    test_geometry_change();
    test_chunk_filler();
    test_address_overflow();
    test_row_climb();
    test_random_traffic();
    drain();
    $display("Covered %0d plane groups and %0d pixels over %0d register settings,",
             groups_sent, pixels_checked, settings_count);
    $display("  all palette codes and %0d wrapped addresses; %0d mismatches",
             overflow_count, mismatches);
    if (mismatches == 0) begin
      $display("planar_sprite_to_argb_sheet test passed");
    end else begin
      $display("planar_sprite_to_argb_sheet test failed");
    end
    $finish;
  end

endmodule
